[src/a2f_pkg.sv]
// Package with shared types, format codes and a leading-zero helper for the sample converter.
`timescale 1ns / 1ps
`default_nettype none
package a2f_pkg;

    localparam logic [2:0] FMT_INT8  = 3'd0;
    localparam logic [2:0] FMT_INT16 = 3'd1;
    localparam logic [2:0] FMT_INT24 = 3'd2;
    localparam logic [2:0] FMT_INT32 = 3'd3;
    localparam logic [2:0] FMT_FP32  = 3'd4;
    localparam logic [2:0] FMT_FP64  = 3'd5;

    typedef struct packed {
        logic               valid;
        logic               special;
        logic [31:0]        spec_val;
        logic               neg;
        logic [63:0]        mag;
        logic signed [11:0] expo;
    } t_dec;

    typedef struct packed {
        logic               valid;
        logic               special;
        logic [31:0]        spec_val;
        logic               neg;
        logic [63:0]        norm;
        logic signed [12:0] bexp;
    } t_nrm;

    function automatic logic [5:0] lead_zeros(input logic [63:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int k = 0; k < 64; k++) begin
            if (v[k]) begin
                n = 6'(63 - k);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[src/a2f_decode.sv]
// First stage: decodes the sample word into sign, magnitude and exponent or a fixed result.
`timescale 1ns / 1ps
`default_nettype none
module a2f_decode (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  wire [63:0]       i_raw_sample,
    input  wire [2:0]        i_sample_format,
    output a2f_pkg::t_dec    o_dec
);

    a2f_pkg::t_dec r_dec;
    a2f_pkg::t_dec n_dec;
    logic signed [31:0] sx;
    logic [31:0] umag;
    logic [10:0] dexp;
    logic [51:0] frac;

    always_comb begin
        n_dec          = '0;
        n_dec.valid    = i_valid;
        sx             = '0;
        dexp           = i_raw_sample[62:52];
        frac           = i_raw_sample[51:0];
        case (i_sample_format)
            a2f_pkg::FMT_INT8: begin
                sx = {{24{i_raw_sample[7]}}, i_raw_sample[7:0]};
                n_dec.expo = -12'sd7;
            end
            a2f_pkg::FMT_INT16: begin
                sx = {{16{i_raw_sample[15]}}, i_raw_sample[15:0]};
                n_dec.expo = -12'sd15;
            end
            a2f_pkg::FMT_INT24: begin
                sx = {{8{i_raw_sample[23]}}, i_raw_sample[23:0]};
                n_dec.expo = -12'sd23;
            end
            a2f_pkg::FMT_INT32: begin
                sx = i_raw_sample[31:0];
                n_dec.expo = -12'sd31;
            end
            default: begin
                sx = '0;
            end
        endcase
        umag = sx[31] ? 32'(-sx) : 32'(sx);
        case (i_sample_format)
            a2f_pkg::FMT_INT8, a2f_pkg::FMT_INT16, a2f_pkg::FMT_INT24,
            a2f_pkg::FMT_INT32: begin
                n_dec.neg      = sx[31];
                n_dec.mag      = {32'd0, umag};
                n_dec.special  = (umag == 32'd0);
                n_dec.spec_val = 32'd0;
            end
            a2f_pkg::FMT_FP32: begin
                n_dec.special  = 1'b1;
                n_dec.spec_val = i_raw_sample[31:0];
            end
            a2f_pkg::FMT_FP64: begin
                n_dec.neg = i_raw_sample[63];
                if (dexp == 11'h7FF) begin
                    n_dec.special = 1'b1;
                    if (frac != 52'd0) begin
                        n_dec.spec_val = {i_raw_sample[63], 8'hFF,
                                          frac[51:29] | 23'h400000};
                    end else begin
                        n_dec.spec_val = {i_raw_sample[63], 8'hFF, 23'd0};
                    end
                end else if (dexp == 11'd0) begin
                    n_dec.special  = (frac == 52'd0);
                    n_dec.spec_val = {i_raw_sample[63], 31'd0};
                    n_dec.mag      = {12'd0, frac};
                    n_dec.expo     = -12'sd1074;
                end else begin
                    n_dec.mag  = {11'd0, 1'b1, frac};
                    n_dec.expo = 12'($signed({1'b0, dexp})) - 12'sd1075;
                end
            end
            default: begin
                n_dec.special  = 1'b1;
                n_dec.spec_val = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec.valid <= 1'b0;
        end else if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_dec = r_dec;

endmodule
`default_nettype wire

[src/a2f_norm.sv]
// Second stage: leading-zero count, normalizing shift and biased exponent.
`timescale 1ns / 1ps
`default_nettype none
module a2f_norm (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  a2f_pkg::t_dec    i_dec,
    output a2f_pkg::t_nrm    o_nrm
);

    a2f_pkg::t_nrm r_nrm;
    a2f_pkg::t_nrm n_nrm;
    logic [5:0] lz;

    always_comb begin
        lz               = a2f_pkg::lead_zeros(i_dec.mag);
        n_nrm.valid      = i_dec.valid;
        n_nrm.special    = i_dec.special;
        n_nrm.spec_val   = i_dec.spec_val;
        n_nrm.neg        = i_dec.neg;
        n_nrm.norm       = i_dec.mag << lz;
        n_nrm.bexp       = 13'sd190 - 13'($signed({1'b0, lz})) + 13'(i_dec.expo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm.valid <= 1'b0;
        end else if (i_en) begin
            r_nrm <= n_nrm;
        end
    end

    assign o_nrm = r_nrm;

endmodule
`default_nettype wire

[src/a2f_round.sv]
// Third stage: rounds to nearest even and packs the single-precision word.
`timescale 1ns / 1ps
`default_nettype none
module a2f_round (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  a2f_pkg::t_nrm    i_nrm,
    output logic             o_valid,
    output logic [31:0]      o_bits
);

    logic         r_valid;
    logic [31:0]  r_bits;
    logic [31:0]  n_bits;
    logic         normal;
    logic [6:0]   sh;
    logic signed [12:0] shw;
    logic [127:0] ext;
    logic [24:0]  m;
    logic [31:0]  sum;

    always_comb begin
        normal = (i_nrm.bexp >= 13'sd1);
        shw    = 13'sd41 - i_nrm.bexp;
        if (normal) begin
            sh = 7'd40;
        end else if (shw > 13'sd65) begin
            sh = 7'd65;
        end else begin
            sh = shw[6:0];
        end
        ext = {i_nrm.norm, 64'd0} >> sh;
        m   = ext[88:64];
        if (ext[63] && ((|ext[62:0]) || m[0])) begin
            m = m + 25'd1;
        end
        if (normal) begin
            sum = {i_nrm.bexp[7:0] - 8'd1, 23'd0} + {7'd0, m};
        end else begin
            sum = {7'd0, m};
        end
        if (sum[30:0] >= 31'h7F800000 || i_nrm.bexp >= 13'sd255) begin
            sum = 32'h7F800000;
        end
        n_bits = i_nrm.special ? i_nrm.spec_val : {i_nrm.neg, sum[30:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_nrm.valid;
            r_bits  <= n_bits;
        end
    end

    assign o_valid = r_valid;
    assign o_bits  = r_bits;

endmodule
`default_nettype wire

[src/audio_sample_to_float32.sv]
// Top level of the audio sample to single-precision float converter.
// The converter takes one sample request per clock while the pipeline advances and presents
// its IEEE single-precision value at the output once it has passed through a decode,
// normalize and round pipeline of three register stages. The whole pipeline advances
// together whenever the output register is empty or being taken, so a sustained rate of
// one sample per cycle holds while the consumer keeps ready high.
// The sample format register resets to float32; the user must write it only while idle, the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module audio_sample_to_float32 (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire [63:0]  i_raw_sample,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [31:0] o_float_bits,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_data
);

    logic [2:0] r_sample_format;
    logic en;
    a2f_pkg::t_dec dec;
    a2f_pkg::t_nrm nrm;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_format <= a2f_pkg::FMT_FP32;
        end else if (i_cfg_we) begin
            r_sample_format <= i_cfg_data;
        end
    end

    a2f_decode u_decode (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_in_valid),
        .i_raw_sample(i_raw_sample), .i_sample_format(r_sample_format), .o_dec(dec)
    );

    a2f_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_dec(dec), .o_nrm(nrm)
    );

    a2f_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_nrm(nrm),
        .o_valid(o_out_valid), .o_bits(o_float_bits)
    );

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_float_bits))
        else $error("stalled result changed");

endmodule
`default_nettype wire

[sim/a2f_checker.sv]
// Checker that predicts and compares converted samples for the sample converter.
`timescale 1ns / 1ps
module a2f_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire [63:0]  i_raw_sample,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire [31:0]  i_float_bits,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    logic [2:0]  fmt_q;
    logic [31:0] float_q[$];

    function automatic logic [31:0] round_single(input logic neg, input logic [63:0] mag,
                                                 input int e);
        logic [31:0] sgn;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] bits;
        int p;
        int be;
        int shift;
        sgn = neg ? 32'h8000_0000 : 32'h0;
        p = 63;
        while (p > 0 && !mag[p]) p--;
        be = p + e + 127;
        if (be >= 255) return sgn | 32'h7F80_0000;
        shift = (be >= 1) ? (p - 23) : (-149 - e);
        if (shift <= 0) begin
            m = mag << (-shift);
        end else if (shift > 64) begin
            return sgn;
        end else begin
            half = 64'd1 << (shift - 1);
            if (shift == 64) begin
                m = 0;
                rem = mag;
            end else begin
                m = mag >> shift;
                rem = mag & ((64'd1 << shift) - 64'd1);
            end
            if (rem > half || (rem == half && m[0])) m++;
        end
        if (be >= 1) bits = (32'(be - 1) << 23) + m[31:0];
        else bits = m[31:0];
        if (bits >= 32'h7F80_0000) bits = 32'h7F80_0000;
        return sgn | bits;
    endfunction

    function automatic logic [31:0] int_to_single(input logic [63:0] x, input int w);
        logic [63:0] sbit;
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        logic neg;
        sbit = 64'd1 << (w - 1);
        mask = (sbit << 1) - 64'd1;
        v = x & mask;
        neg = (v & sbit) != 0;
        mag = neg ? ((~v + 64'd1) & mask) : v;
        if (neg && mag == 0) mag = sbit;
        if (mag == 0) return 32'h0;
        return round_single(neg, mag, -(w - 1));
    endfunction

    function automatic logic [31:0] double_to_single(input logic [63:0] x);
        logic [31:0] sgn;
        logic [10:0] ex;
        logic [63:0] frac;
        sgn = x[63] ? 32'h8000_0000 : 32'h0;
        ex = x[62:52];
        frac = {12'd0, x[51:0]};
        if (ex == 11'h7FF) begin
            if (frac != 0) return sgn | 32'h7FC0_0000 | 32'(frac >> 29);
            return sgn | 32'h7F80_0000;
        end
        if (ex == 0) begin
            if (frac == 0) return sgn;
            return round_single(x[63], frac, -1074);
        end
        return round_single(x[63], frac | 64'h0010_0000_0000_0000, int'(ex) - 1075);
    endfunction

    function automatic logic [31:0] convert_sample(input logic [2:0] f, input logic [63:0] x);
        case (f)
            a2f_pkg::FMT_INT8: return int_to_single(x, 8);
            a2f_pkg::FMT_INT16: return int_to_single(x, 16);
            a2f_pkg::FMT_INT24: return int_to_single(x, 24);
            a2f_pkg::FMT_INT32: return int_to_single(x, 32);
            a2f_pkg::FMT_FP32: return x[31:0];
            a2f_pkg::FMT_FP64: return double_to_single(x);
            default: return 32'h0;
        endcase
    endfunction

    assign o_pending = float_q.size();

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            fmt_q <= a2f_pkg::FMT_FP32;
            o_errors <= 0;
        end else begin
            if (i_cfg_we) fmt_q <= i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                float_q = {float_q, convert_sample(fmt_q, i_raw_sample)};
            end
            if (i_out_valid && i_out_ready) begin
                if (float_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_float_bits);
                    o_errors <= o_errors + 1;
                end else begin
                    want = float_q.pop_front();
                    if (want !== i_float_bits) begin
                        $display("%0t: float_bits mismatch, expected %h, actual %h",
                                 $time, want, i_float_bits);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[sim/testbench.sv]
// Top of the sample converter testbench: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module testbench;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] raw_sample;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] float_bits;
    logic        cfg_we;
    logic [2:0]  cfg_data;
    int          errors;
    int          pending;
    int          idle_cycles;
    int          sent;
    bit          stimulus_done;
    int          out_wait;
    bit          out_taken;

    localparam int WATCHDOG = 2000;

    audio_sample_to_float32 DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_raw_sample(raw_sample),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_float_bits(float_bits),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    a2f_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_raw_sample(raw_sample),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_float_bits(float_bits),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The consumer draws a number of stall cycles for each result after taking the last one.
    always @(posedge clk) begin
        out_taken <= rst_n && out_valid && out_ready;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_wait = $urandom_range(0, 16);
        end else if (out_taken || !out_ready) begin
            if (out_taken) out_wait = $urandom_range(0, 16);
            else if (out_wait > 0) out_wait = out_wait - 1;
            out_ready <= (out_wait == 0);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("Watchdog expired with %0d results outstanding.", pending);
            $display("[audio_sample_to_float32] ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic [63:0] value, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 16) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        raw_sample <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic write_format(input logic [2:0] f);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= f;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] random_word(input logic [2:0] f);
        logic [63:0] w;
        logic [10:0] ex;
        w = {$urandom, $urandom};
        if (f == a2f_pkg::FMT_FP64) begin
            case ($urandom_range(0, 7))
                0: ex = 11'h7FF;
                1: ex = 11'h0;
                2: ex = 11'(1023 - 126 - $urandom_range(0, 30));
                3: ex = 11'(1023 + 127 + $urandom_range(0, 2));
                4: ex = 11'($urandom);
                default: ex = 11'($urandom_range(1023 - 126, 1023 + 127));
            endcase
            w[62:52] = ex;
            if ($urandom_range(0, 5) == 0) w[28:0] = {1'b1, 28'd0};
        end else if ($urandom_range(0, 7) == 0) begin
            w[31:0] = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h0;
        end
        return w;
    endfunction

    initial begin
        logic [2:0] plan[$];
        logic [63:0] edge_vals[$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        raw_sample = 64'd0;
        cfg_we = 1'b0;
        cfg_data = a2f_pkg::FMT_FP32;
        sent = 0;
        stimulus_done = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        edge_vals = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7F, 64'h80, 64'h7FFF, 64'h8000,
                      64'hFF7F_FFFF, 64'h0080_0000, 64'h7FFF_FFFF, 64'h8000_0000,
                      64'h7FF8_0000_0000_0001, 64'hFFF0_0000_0000_0000,
                      64'h47F0_0000_0000_0000, 64'h8000_0000_0000_0000,
                      64'h3690_0000_0000_0000, 64'h0000_0000_0000_0001,
                      64'h7FC0_1234_0000_0001, 64'h3FF0_0000_1000_0000,
                      64'h3FF0_0000_3000_0000};
        // Reset format first, then every format code with every other extreme word.
        foreach (edge_vals[i]) send_request(edge_vals[i], 0);
        for (int f = 0; f < 8; f++) begin
            write_format(3'(f));
            for (int i = 0; i < 10; i++) send_request(edge_vals[i * 2 % edge_vals.size()], 1);
        end

        plan = '{a2f_pkg::FMT_FP64, a2f_pkg::FMT_INT32, a2f_pkg::FMT_INT8,
                 a2f_pkg::FMT_FP64, a2f_pkg::FMT_INT24, a2f_pkg::FMT_INT16,
                 3'd7, a2f_pkg::FMT_FP64, a2f_pkg::FMT_FP32, 3'd6,
                 a2f_pkg::FMT_INT32, a2f_pkg::FMT_FP64};
        foreach (plan[p]) begin
            write_format(plan[p]);
            for (int i = 0; i < 100; i++) begin
                send_request(random_word(plan[p]), (p % 3) != 0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        $display("Sent %0d samples across all eight format codes,", sent);
        $display("with random producer gaps and consumer stalls.");
        if (errors == 0) begin
            $display("[audio_sample_to_float32] OK");
        end else begin
            $display("[audio_sample_to_float32] ERROR");
        end
        $finish;
    end
endmodule
